>>> hw/rtl/lpbb_pkg.sv
package lpbb_pkg;

   localparam int DUTY_W = 7;
   localparam int CNT_W = 7;
   localparam int STEP_W = 8;
   localparam int HOLD_W = 4;
   localparam int REQ_W = 3;

   localparam int PWM_STEPS_DEFAULT = 100;

   localparam int BLINK_UNIT_MS = 100;
   localparam int RAMP_STEP_MS = 5;
   localparam int DARK_HOLD_MS = 50;
   localparam int FULL_HOLD_MS = 5;
   localparam int ENDLESS_REPEAT = 100;

   localparam int UNIT_W = $clog2(BLINK_UNIT_MS);
   localparam int RAMP_W = $clog2(RAMP_STEP_MS);

   localparam logic [HOLD_W-1:0] DARK_HOLD_STEPS = HOLD_W'(DARK_HOLD_MS / RAMP_STEP_MS);
   localparam logic [HOLD_W-1:0] FULL_HOLD_STEPS = HOLD_W'(FULL_HOLD_MS / RAMP_STEP_MS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK    = 3'd0,
      REQ_ON      = 3'd1,
      REQ_OFF     = 3'd2,
      REQ_TOGGLE  = 3'd3,
      REQ_BREATHE = 3'd4,
      REQ_BLINK   = 3'd5
   } req_code_type;

   typedef enum logic {
      REG_BLINK_PERIOD  = 1'b0,
      REG_BLINK_ON_TIME = 1'b1
   } reg_index_type;

   // Blink timing registers plus a strobe that restarts the timebase on any write.
   typedef struct packed {
      logic [CNT_W-1:0] blink_period;
      logic [CNT_W-1:0] blink_on_time;
      logic             restart;
   } blink_cfg_type;

   typedef struct packed {
      logic              breathe_active;
      logic              blink_active;
      logic [DUTY_W-1:0] duty_level;
      logic              pin_level;
   } led_status_type;

endpackage

>>> hw/rtl/lpbb_csr.sv
module lpbb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lpbb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lpbb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lpbb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output lpbb_pkg::blink_cfg_type            blink_cfg
);
   import lpbb_pkg::*;

   logic [CNT_W-1:0] period_ff, period_in;
   logic [CNT_W-1:0] on_time_ff, on_time_in;
   logic             write_strobe;
   logic             reg_sel;

   assign csr_pready   = 1'b1;
   assign write_strobe = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel      = csr_paddr[CSR_ADDR_W-1];

   always_comb begin
      period_in  = period_ff;
      on_time_in = on_time_ff;
      if (write_strobe) begin
         case (reg_sel)
            REG_BLINK_PERIOD:  period_in  = csr_pwdata[CNT_W-1:0];
            REG_BLINK_ON_TIME: on_time_in = csr_pwdata[CNT_W-1:0];
            default:           period_in  = period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= CNT_W'(3);
         on_time_ff <= CNT_W'(2);
      end else begin
         period_ff  <= period_in;
         on_time_ff <= on_time_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_BLINK_PERIOD:  csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, period_ff};
         REG_BLINK_ON_TIME: csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, on_time_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign blink_cfg.blink_period  = period_ff;
   assign blink_cfg.blink_on_time = on_time_ff;
   assign blink_cfg.restart       = write_strobe;

endmodule

>>> hw/rtl/lpbb_core.sv
module lpbb_core #(
   parameter int PWM_STEPS = lpbb_pkg::PWM_STEPS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_valid,
   input  logic [lpbb_pkg::REQ_W-1:0]    req_type,
   input  logic [lpbb_pkg::CNT_W-1:0]    flash_count,
   input  logic [lpbb_pkg::CNT_W-1:0]    pause_count,
   input  logic [lpbb_pkg::CNT_W-1:0]    repeat_count,
   input  lpbb_pkg::blink_cfg_type       blink_cfg,
   output lpbb_pkg::led_status_type      status_next
);
   import lpbb_pkg::*;

   localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'(PWM_STEPS);

   // The millisecond count wraps at a multiple of both the blink unit and the
   // ramp step, so only its residues are kept.
   logic [UNIT_W-1:0] unit_ms_ff, unit_ms_in;
   logic [RAMP_W-1:0] ramp_ms_ff, ramp_ms_in;
   logic [DUTY_W-1:0] pwm_phase_ff, pwm_phase_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic              out_state_ff, out_state_in;
   logic              breathing_ff, breathing_in;
   logic              breathe_down_ff, breathe_down_in;
   logic [HOLD_W-1:0] hold_count_ff, hold_count_in;
   logic [CNT_W-1:0]  blink_clock_ff, blink_clock_in;
   logic [STEP_W-1:0] blink_step_ff, blink_step_in;
   logic [CNT_W-1:0]  blink_flashes_ff, blink_flashes_in;
   logic [CNT_W-1:0]  blink_pauses_ff, blink_pauses_in;
   logic [CNT_W-1:0]  blink_repeats_ff, blink_repeats_in;
   logic [CNT_W-1:0]  blink_round_ff, blink_round_in;

   logic [STEP_W-1:0] round_len;
   logic [CNT_W-1:0]  clock_inc;
   logic [STEP_W-1:0] step_inc;
   logic [CNT_W-1:0]  round_inc;
   logic [HOLD_W-1:0] hold_inc;
   logic [DUTY_W-1:0] phase_inc;
   logic              unit_edge;
   logic              ramp_edge;

   assign round_len = {1'b0, blink_flashes_ff} + {1'b0, blink_pauses_ff};
   assign clock_inc = blink_clock_ff + CNT_W'(1);
   assign step_inc  = blink_step_ff + STEP_W'(1);
   assign round_inc = blink_round_ff + CNT_W'(1);
   assign hold_inc  = hold_count_ff + HOLD_W'(1);
   assign phase_inc = pwm_phase_ff + DUTY_W'(1);

   always_comb begin
      unit_ms_in       = unit_ms_ff;
      ramp_ms_in       = ramp_ms_ff;
      pwm_phase_in     = pwm_phase_ff;
      duty_in          = duty_ff;
      out_state_in     = out_state_ff;
      breathing_in     = breathing_ff;
      breathe_down_in  = breathe_down_ff;
      hold_count_in    = hold_count_ff;
      blink_clock_in   = blink_clock_ff;
      blink_step_in    = blink_step_ff;
      blink_flashes_in = blink_flashes_ff;
      blink_pauses_in  = blink_pauses_ff;
      blink_repeats_in = blink_repeats_ff;
      blink_round_in   = blink_round_ff;
      unit_edge        = 1'b0;
      ramp_edge        = 1'b0;

      if (step_valid) begin
         case (req_type)
            REQ_TICK: begin
               if (unit_ms_ff == UNIT_W'(BLINK_UNIT_MS - 1)) begin
                  unit_ms_in = '0;
                  unit_edge  = 1'b1;
               end else begin
                  unit_ms_in = unit_ms_ff + UNIT_W'(1);
               end
               if (ramp_ms_ff == RAMP_W'(RAMP_STEP_MS - 1)) begin
                  ramp_ms_in = '0;
                  ramp_edge  = 1'b1;
               end else begin
                  ramp_ms_in = ramp_ms_ff + RAMP_W'(1);
               end

               // Blink sequencer, one move per blink unit.
               if (unit_edge && (blink_flashes_ff != '0)) begin
                  blink_clock_in = clock_inc;
                  if (clock_inc >= blink_cfg.blink_period) begin
                     blink_clock_in = '0;
                     blink_step_in  = step_inc;
                     if (step_inc >= round_len) begin
                        blink_step_in  = '0;
                        blink_round_in = round_inc;
                        if (round_inc >= blink_repeats_ff) begin
                           blink_round_in = '0;
                           if (blink_repeats_ff < CNT_W'(ENDLESS_REPEAT)) begin
                              blink_flashes_in = '0;
                           end
                        end
                     end
                  end else if (clock_inc >= blink_cfg.blink_on_time) begin
                     duty_in = '0;
                  end else if (blink_step_ff < {1'b0, blink_flashes_ff}) begin
                     duty_in = FULL_DUTY;
                  end
               end

               // The ramp runs after the blink update and wins on the duty.
               if (ramp_edge && breathing_ff) begin
                  if (breathe_down_ff) begin
                     if (duty_in != '0) begin
                        duty_in       = duty_in - DUTY_W'(1);
                        hold_count_in = '0;
                     end else begin
                        hold_count_in = hold_inc;
                        if (hold_inc >= DARK_HOLD_STEPS) begin
                           breathe_down_in = 1'b0;
                        end
                     end
                  end else begin
                     if (duty_in < FULL_DUTY) begin
                        duty_in       = duty_in + DUTY_W'(1);
                        hold_count_in = '0;
                     end else begin
                        hold_count_in = hold_inc;
                        if (hold_inc >= FULL_HOLD_STEPS) begin
                           breathe_down_in = 1'b1;
                        end
                     end
                  end
               end

               pwm_phase_in = (phase_inc >= FULL_DUTY) ? '0 : phase_inc;
               out_state_in = (pwm_phase_in < duty_in);
            end
            REQ_ON: begin
               breathing_in     = 1'b0;
               blink_flashes_in = '0;
               duty_in          = FULL_DUTY;
               out_state_in     = 1'b1;
            end
            REQ_OFF: begin
               breathing_in     = 1'b0;
               blink_flashes_in = '0;
               duty_in          = '0;
               out_state_in     = 1'b0;
            end
            REQ_TOGGLE: begin
               breathing_in     = 1'b0;
               blink_flashes_in = '0;
               duty_in          = out_state_ff ? '0 : FULL_DUTY;
               out_state_in     = ~out_state_ff;
            end
            REQ_BREATHE: begin
               duty_in         = '0;
               breathe_down_in = 1'b0;
               hold_count_in   = '0;
               breathing_in    = 1'b1;
            end
            REQ_BLINK: begin
               blink_flashes_in = flash_count;
               blink_pauses_in  = pause_count;
               blink_repeats_in = repeat_count;
               blink_step_in    = '0;
               blink_round_in   = '0;
            end
            default: begin
               duty_in = duty_ff;
            end
         endcase
      end

      if (blink_cfg.restart) begin
         blink_clock_in = '0;
         unit_ms_in     = '0;
         ramp_ms_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ms_ff       <= '0;
         ramp_ms_ff       <= '0;
         pwm_phase_ff     <= '0;
         duty_ff          <= '0;
         out_state_ff     <= 1'b0;
         breathing_ff     <= 1'b0;
         breathe_down_ff  <= 1'b0;
         hold_count_ff    <= '0;
         blink_clock_ff   <= '0;
         blink_step_ff    <= '0;
         blink_flashes_ff <= '0;
         blink_pauses_ff  <= '0;
         blink_repeats_ff <= '0;
         blink_round_ff   <= '0;
      end else begin
         unit_ms_ff       <= unit_ms_in;
         ramp_ms_ff       <= ramp_ms_in;
         pwm_phase_ff     <= pwm_phase_in;
         duty_ff          <= duty_in;
         out_state_ff     <= out_state_in;
         breathing_ff     <= breathing_in;
         breathe_down_ff  <= breathe_down_in;
         hold_count_ff    <= hold_count_in;
         blink_clock_ff   <= blink_clock_in;
         blink_step_ff    <= blink_step_in;
         blink_flashes_ff <= blink_flashes_in;
         blink_pauses_ff  <= blink_pauses_in;
         blink_repeats_ff <= blink_repeats_in;
         blink_round_ff   <= blink_round_in;
      end
   end

   assign status_next.pin_level      = out_state_in;
   assign status_next.duty_level     = duty_in;
   assign status_next.blink_active   = (blink_flashes_in != '0);
   assign status_next.breathe_active = breathing_in;

endmodule

>>> hw/rtl/led_pwm_breathe_blink_controller.sv
// Single-channel LED controller with a PWM of PWM_STEPS steps, a breathing
// ramp and a blink sequencer. Each request transfer (tuser = request code: tick,
// on, off, toggle, start breathing, start blink) yields exactly one response
// transfer carrying the pin level, duty and activity flags after that request.
// The block sustains one request per clock while the response side is ready: a
// request is registered on acceptance, the core computes the whole state update
// combinationally, and the response is then registered in the output register once
// that register is free or drains. The blink timing registers sit on the
// APB port at byte addresses 0 (period) and 4 (on time); writing either one
// restarts the millisecond timebase and the blink clock.
module led_pwm_breathe_blink_controller #(
   parameter int PWM_STEPS = lpbb_pkg::PWM_STEPS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: flash_count[6:0], pause_count[13:7], repeat_count[20:14], zero pad
   input  logic [lpbb_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: req_type[2:0]
   input  logic [lpbb_pkg::REQ_W-1:0]         req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: pin_level[0], duty_level[7:1], blink_active[8],
   // breathe_active[9], zero pad
   output logic [lpbb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lpbb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lpbb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lpbb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import lpbb_pkg::*;

   localparam int STATUS_W = $bits(led_status_type);

   logic                 in_valid_ff, in_valid_in;
   logic [REQ_W-1:0]     req_type_ff;
   logic [CNT_W-1:0]     flash_count_ff;
   logic [CNT_W-1:0]     pause_count_ff;
   logic [CNT_W-1:0]     repeat_count_ff;
   logic                 out_valid_ff, out_valid_in;
   led_status_type       status_ff;
   led_status_type       status_next;
   blink_cfg_type        blink_cfg;
   logic                 advance;
   logic                 req_take;

   // The held request moves on whenever the response register is free or
   // its transfer completes this cycle.
   assign advance    = ~out_valid_ff | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_type_ff     <= req_tuser;
         flash_count_ff  <= req_tdata[CNT_W-1:0];
         pause_count_ff  <= req_tdata[2*CNT_W-1:CNT_W];
         repeat_count_ff <= req_tdata[3*CNT_W-1:2*CNT_W];
      end
      if (advance && in_valid_ff) begin
         status_ff <= status_next;
      end
   end

   lpbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .blink_cfg   (blink_cfg)
   );

   lpbb_core #(
      .PWM_STEPS (PWM_STEPS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (in_valid_ff & advance),
      .req_type     (req_type_ff),
      .flash_count  (flash_count_ff),
      .pause_count  (pause_count_ff),
      .repeat_count (repeat_count_ff),
      .blink_cfg    (blink_cfg),
      .status_next  (status_next)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-STATUS_W){1'b0}}, status_ff};

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lpbb_pkg::*;

   localparam int CLK_PERIOD = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MS_WRAP = 60000;
   localparam int PWM_STEPS = PWM_STEPS_DEFAULT;
   localparam int RANDOM_ITEMS = 1850;
   localparam int DIRECTED_ROWS = 23;
   localparam int PHASE_ITEMS = 700;
   localparam int LONG_STALL_CYCLES = 64;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_RAMP_TICKS = 1150;

   // Request codes that the block has no meaning for.
   localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

   typedef enum int {
      EP_BREATHE,
      EP_BLINK,
      EP_BOTH,
      EP_MIXED
   } episode_kind_type;

   typedef struct {
      logic [REQ_W-1:0] code;
      int               flashes;
      int               pauses;
      int               repeats;
      bit               typed;
      bit               pin;
      int               duty;
      bit               blink;
      bit               breathe;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_W-1:0]       req_tuser;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Model of the LED state.
   logic [15:0]        led_ms;
   logic [CNT_W-1:0]   pwm_phase;
   logic [DUTY_W-1:0]  led_duty;
   logic               led_out;
   logic               breathing;
   logic               ramp_down;
   logic [HOLD_W-1:0]  hold_cnt;
   logic [CNT_W-1:0]   blink_clk;
   logic [STEP_W-1:0]  blink_step;
   logic [CNT_W-1:0]   blink_flashes;
   logic [CNT_W-1:0]   blink_pauses;
   logic [CNT_W-1:0]   blink_repeats;
   logic [CNT_W-1:0]   blink_round;
   logic [CNT_W-1:0]   cfg_period;
   logic [CNT_W-1:0]   cfg_on_time;

   led_status_type pending_status_q[$];
   int             errors = 0;
   int             cycles = 0;
   int             requests_sent = 0;
   int             idle_phase = 0;
   bit             long_stall_armed = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{REQ_TICK,       0,   0,   0, 1'b1, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_ON,         0,   0,   0, 1'b1, 1'b1, 100, 1'b0, 1'b0},
      '{REQ_TICK,       0,   0,   0, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_TOGGLE,     0,   0,   0, 1'b1, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_TOGGLE,     0,   0,   0, 1'b1, 1'b1, 100, 1'b0, 1'b0},
      '{REQ_OFF,      127, 127, 127, 1'b1, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_SPARE_LO,   0,   0,   0, 1'b1, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_SPARE_HI, 127, 127, 127, 1'b1, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_BREATHE,    0,   0,   0, 1'b1, 1'b0,   0, 1'b0, 1'b1},
      '{REQ_TICK,       0,   0,   0, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_TICK,     127, 127, 127, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_TICK,       0,   0,   0, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_BLINK,    127, 127, 127, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_TICK,       0,   0,   0, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_BLINK,      0,   0,   0, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_ON,         0,   0,   0, 1'b1, 1'b1, 100, 1'b0, 1'b0},
      '{REQ_BLINK,      1,   0,   0, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_BREATHE,    0,   0,   0, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_OFF,        0,   0,   0, 1'b1, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_BLINK,     85,  42, 100, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_BLINK,     42,  85,  99, 1'b0, 1'b0,   0, 1'b0, 1'b0},
      '{REQ_TOGGLE,     0,   0,   0, 1'b1, 1'b1, 100, 1'b0, 1'b0},
      '{REQ_OFF,        0,   0,   0, 1'b1, 1'b0,   0, 1'b0, 1'b0}
   };

   led_pwm_breathe_blink_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Advances the model by one request and returns the status it reports.
   function automatic led_status_type led_next_status(input logic [REQ_W-1:0] code,
                                                      input logic [CNT_W-1:0] flashes_in,
                                                      input logic [CNT_W-1:0] pauses_in,
                                                      input logic [CNT_W-1:0] repeats_in);
      led_status_type st;
      bit             lit;
      case (code)
         REQ_TICK: begin
            if (int'(led_ms) + 1 >= MS_WRAP) led_ms = '0;
            else led_ms = led_ms + 1'b1;
            if (blink_flashes != 0 && int'(led_ms) % BLINK_UNIT_MS == 0) begin
               blink_clk = blink_clk + 1'b1;
               if (blink_clk >= cfg_period) begin
                  blink_clk = '0;
                  blink_step = blink_step + 1'b1;
                  if (int'(blink_step) >= int'(blink_flashes) + int'(blink_pauses)) begin
                     blink_step = '0;
                     blink_round = blink_round + 1'b1;
                     if (blink_round >= blink_repeats) begin
                        blink_round = '0;
                        if (int'(blink_repeats) < ENDLESS_REPEAT) blink_flashes = '0;
                     end
                  end
               end else if (blink_clk >= cfg_on_time) begin
                  led_duty = '0;
               end else if (int'(blink_step) < int'(blink_flashes)) begin
                  led_duty = DUTY_W'(PWM_STEPS);
               end
            end
            // The ramp runs after blink, so it has the last word on the duty.
            if (breathing && int'(led_ms) % RAMP_STEP_MS == 0) begin
               if (ramp_down) begin
                  if (led_duty != 0) begin
                     led_duty = led_duty - 1'b1;
                     hold_cnt = '0;
                  end else begin
                     hold_cnt = hold_cnt + 1'b1;
                     if (hold_cnt >= DARK_HOLD_STEPS) ramp_down = 1'b0;
                  end
               end else begin
                  if (int'(led_duty) < PWM_STEPS) begin
                     led_duty = led_duty + 1'b1;
                     hold_cnt = '0;
                  end else begin
                     hold_cnt = hold_cnt + 1'b1;
                     if (hold_cnt >= FULL_HOLD_STEPS) ramp_down = 1'b1;
                  end
               end
            end
            pwm_phase = pwm_phase + 1'b1;
            if (int'(pwm_phase) >= PWM_STEPS) pwm_phase = '0;
            led_out = (pwm_phase < led_duty);
         end
         REQ_ON, REQ_OFF, REQ_TOGGLE: begin
            lit = (code == REQ_ON) || (code == REQ_TOGGLE && !led_out);
            breathing = 1'b0;
            blink_flashes = '0;
            led_duty = lit ? DUTY_W'(PWM_STEPS) : '0;
            led_out = lit;
         end
         REQ_BREATHE: begin
            led_duty = '0;
            ramp_down = 1'b0;
            hold_cnt = '0;
            breathing = 1'b1;
         end
         REQ_BLINK: begin
            blink_flashes = flashes_in;
            blink_pauses = pauses_in;
            blink_repeats = repeats_in;
            blink_step = '0;
            blink_round = '0;
         end
         default: ;
      endcase
      st.pin_level = led_out;
      st.duty_level = led_duty;
      st.blink_active = (blink_flashes != 0);
      st.breathe_active = breathing;
      return st;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_request(input logic [REQ_W-1:0] code,
                               input logic [CNT_W-1:0] flashes_in,
                               input logic [CNT_W-1:0] pauses_in,
                               input logic [CNT_W-1:0] repeats_in,
                               input bit typed,
                               input led_status_type typed_status);
      led_status_type predicted;
      int             idle_pct;
      idle_phase = (requests_sent < PHASE_ITEMS) ? 0 : (requests_sent < 2 * PHASE_ITEMS) ? 1 : 2;
      idle_pct = (idle_phase == 0) ? 30 : (idle_phase == 1) ? 51 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {3'b000, repeats_in, pauses_in, flashes_in};
      do @(posedge clock); while (!req_tready);
      predicted = led_next_status(code, flashes_in, pauses_in, repeats_in);
      pending_status_q.push_back(typed ? typed_status : predicted);
      requests_sent++;
      if (requests_sent == 300 || requests_sent == 1000 || requests_sent == 1600)
         long_stall_armed = 1'b1;
      @(negedge clock);
   endtask

   // Stops offering requests and waits at a falling edge until all responses are in.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_status_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_blink_reg(input reg_index_type idx, input logic [CNT_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata <= ($urandom() & ~32'h7F) | CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_BLINK_PERIOD) cfg_period = value;
      else cfg_on_time = value;
      // Any write restarts the millisecond timebase and the blink clock.
      blink_clk = '0;
      led_ms = '0;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_episode(input episode_kind_type kind, input int len, input int noise_pct);
      logic [CNT_W-1:0] f;
      logic [CNT_W-1:0] p;
      logic [CNT_W-1:0] r;
      if (kind == EP_BREATHE || kind == EP_BOTH)
         send_request(REQ_BREATHE, '0, '0, '0, 1'b0, '0);
      if (kind == EP_BLINK || kind == EP_BOTH) begin
         if ($urandom_range(0, 4) == 0) begin
            f = CNT_W'($urandom_range(0, 127));
            p = CNT_W'($urandom_range(0, 127));
            r = CNT_W'($urandom_range(0, 127));
         end else begin
            f = CNT_W'($urandom_range(1, 3));
            p = CNT_W'($urandom_range(0, 2));
            r = ($urandom_range(0, 5) == 0) ? CNT_W'($urandom_range(100, 127))
                                             : CNT_W'($urandom_range(0, 2));
         end
         send_request(REQ_BLINK, f, p, r, 1'b0, '0);
      end
      repeat (len) begin
         f = CNT_W'($urandom_range(0, 127));
         p = CNT_W'($urandom_range(0, 127));
         r = CNT_W'($urandom_range(0, 127));
         if ($urandom_range(0, 99) < noise_pct)
            send_request(REQ_W'($urandom_range(1, 7)), f, p, r, 1'b0, '0);
         else
            send_request(REQ_TICK, f, p, r, 1'b0, '0);
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_armed) begin
            long_stall_armed = 1'b0;
            repeat (LONG_STALL_CYCLES) begin
               rsp_tready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >=
                        ((idle_phase == 0) ? 51 : (idle_phase == 1) ? 30 : 0));
      end
   end

   always @(posedge clock) begin : check_responses
      led_status_type want;
      led_status_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = led_status_type'(rsp_tdata[9:0]);
         if (pending_status_q.size() == 0) begin
            $display("%0t: response transfer with nothing pending: %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_status_q.pop_front();
            if (got.pin_level !== want.pin_level || got.duty_level !== want.duty_level ||
                got.blink_active !== want.blink_active ||
                got.breathe_active !== want.breathe_active) begin
               $display("%0t: mismatch expected pin=%0d duty=%0d blink=%0d breathe=%0d",
                        $time, want.pin_level, want.duty_level, want.blink_active,
                        want.breathe_active);
               $display("%0t:          actual   pin=%0d duty=%0d blink=%0d breathe=%0d",
                        $time, got.pin_level, got.duty_level, got.blink_active,
                        got.breathe_active);
               errors++;
            end
         end
      end
   end

   initial begin
      led_status_type   typed_status;
      directed_row_type row;
      logic [CNT_W-1:0] period_val;
      logic [CNT_W-1:0] on_val;
      episode_kind_type kind;
      int               episode;
      int               sel;
      int               len_val;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_TICK;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      led_ms = '0;
      pwm_phase = '0;
      led_duty = '0;
      led_out = 1'b0;
      breathing = 1'b0;
      ramp_down = 1'b0;
      hold_cnt = '0;
      blink_clk = '0;
      blink_step = '0;
      blink_flashes = '0;
      blink_pauses = '0;
      blink_repeats = '0;
      blink_round = '0;
      cfg_period = CNT_W'(3);
      cfg_on_time = CNT_W'(2);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         typed_status.pin_level = row.pin;
         typed_status.duty_level = DUTY_W'(row.duty);
         typed_status.blink_active = row.blink;
         typed_status.breathe_active = row.breathe;
         send_request(row.code, CNT_W'(row.flashes), CNT_W'(row.pauses), CNT_W'(row.repeats),
                      row.typed, typed_status);
      end

      episode = 0;
      while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         wait_for_drain();
         if (episode == 0) begin
            write_blink_reg(REG_BLINK_PERIOD, CNT_W'(1));
            write_blink_reg(REG_BLINK_ON_TIME, CNT_W'(1));
         end else if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
               0: begin period_val = '0; on_val = '0; end
               1: begin period_val = '0; on_val = '1; end
               2: begin period_val = '1; on_val = '0; end
               3: begin period_val = '1; on_val = '1; end
               default: begin
                  period_val = CNT_W'($urandom_range(0, 3));
                  on_val = CNT_W'($urandom_range(0, 4));
               end
            endcase
            sel = $urandom_range(0, 3);
            if (sel != 1) write_blink_reg(REG_BLINK_PERIOD, period_val);
            if (sel != 2) write_blink_reg(REG_BLINK_ON_TIME, on_val);
         end
         // The first episode is a clean ramp long enough to pass both holds.
         if (episode == 0) begin
            run_episode(EP_BREATHE, LONG_RAMP_TICKS, 0);
         end else begin
            kind = episode_kind_type'($urandom_range(0, 3));
            len_val = $urandom_range(120, 450);
            if (len_val > DIRECTED_ROWS + RANDOM_ITEMS - requests_sent)
               len_val = DIRECTED_ROWS + RANDOM_ITEMS - requests_sent;
            run_episode(kind, len_val, (kind == EP_MIXED) ? 40 : 2);
         end
         episode++;
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
